/* hw/rtl/svf_pkg.sv */
// ----------------------------------------------------------------------------
// svf_pkg
// Shared types, constants and the 2^(-i/16) table for the softmax block.
// ----------------------------------------------------------------------------
`default_nettype none

package svf_pkg;

  // Maximum number of stored elements per vector
  localparam int unsigned VecLen = 16;
  localparam int unsigned CntW   = $clog2(VecLen + 1);
  localparam int unsigned IdxW   = (VecLen > 1) ? $clog2(VecLen) : 1;

  localparam int unsigned ScoreW = 16;
  localparam int unsigned ProbW  = 16;
  localparam int unsigned EIdxW  = 6;
  localparam int unsigned ExpW   = 17;  // exp value, 65536 means 1.0
  localparam int unsigned SumW   = 23;  // Q7.16 sum

  localparam logic [16:0]     Log2eQ16 = 17'd94549;
  localparam logic [SumW-1:0] SumMax   = {SumW{1'b1}};

  // Vector handed from the front end to the back end
  typedef struct packed {
    logic [CntW-1:0]          n;
    logic signed [ScoreW-1:0] max;
  } job_t;

  // Read request into the element store
  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
  } rd_req_t;

  // round(65536 * 2^(-i/16)), i = 0..16
  function automatic logic [16:0] pow2_lut(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/softmax_vector_forward.sv */
// ----------------------------------------------------------------------------
// softmax_vector_forward
// Max-shifted fixed-point softmax over one vector of up to 16 scores.
//
//  channel   dir  handshake           payload
//  command   in   start / busy        score_i, last_in_i
//  result    out  valid_o strobe      prob_o, elem_index_o, last_out_o
//
// Elements load one per cycle while busy is low. On the element marked last,
// busy rises and the back end walks the vector: a pipelined exp sum pass,
// then per element a store read, the 4-stage exp unit and a 17-step
// restoring divider, which yields one result per element.
// Each result is on the ports for one cycle; the receiver cannot stall.
// Reset clears count, maximum, queue and sequencer; the store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module softmax_vector_forward (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [svf_pkg::ScoreW-1:0] score_i,
  input  wire logic                              last_in_i,
  output logic                                   valid_o,
  output logic [svf_pkg::ProbW-1:0]              prob_o,
  output logic [svf_pkg::EIdxW-1:0]              elem_index_o,
  output logic                                   last_out_o
);
  import svf_pkg::*;

  logic    accept, push, pop, empty, idle;
  job_t    job_in, job_out;
  rd_req_t rd_req;
  logic [ScoreW-1:0] rd_data;

  assign busy   = !empty || !idle;
  assign accept = start && !busy;

  svf_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .score_i   (score_i),
    .last_in_i (last_in_i),
    .push_o    (push),
    .job_o     (job_in),
    .rd_req_i  (rd_req),
    .rd_data_o (rd_data)
  );

  svf_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (job_out)
  );

  svf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_vld_i    (!empty),
    .job_i        (job_out),
    .pop_o        (pop),
    .idle_o       (idle),
    .rd_req_o     (rd_req),
    .rd_data_i    (rd_data),
    .valid_o      (valid_o),
    .prob_o       (prob_o),
    .elem_index_o (elem_index_o),
    .last_out_o   (last_out_o)
  );

`ifndef SYNTHESIS
  // Results only appear while a vector is being processed
  a_out_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy) else $error("result outside busy window");

  // The last result of a vector is followed by a gap
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_out_o |=> !valid_o) else $error("result right after last");

  // Busy only rises after an accepted last-flagged transaction
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && last_in_i)) else $error("busy rose unprompted");
`endif

endmodule

`default_nettype wire

/* hw/rtl/svf_front.sv */
// ----------------------------------------------------------------------------
// svf_front
// Accepts elements, stores them, tracks count and maximum, emits vector jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module svf_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           accept_i,
  input  wire logic signed [svf_pkg::ScoreW-1:0] score_i,
  input  wire logic                           last_in_i,
  output logic                                push_o,
  output svf_pkg::job_t                       job_o,
  input  wire svf_pkg::rd_req_t               rd_req_i,
  output logic [svf_pkg::ScoreW-1:0]          rd_data_o
);
  import svf_pkg::*;

  logic [ScoreW-1:0]        store_q [VecLen];
  logic [CntW-1:0]          cnt_q, cnt_d, cnt_new;
  logic signed [ScoreW-1:0] max_q, max_d, max_new;
  logic                     room;

  // Element goes in only while the vector has room
  always_comb begin
    room    = (cnt_q < CntW'(VecLen));
    cnt_new = cnt_q;
    max_new = max_q;
    if (room) begin
      cnt_new = cnt_q + CntW'(1);
      if (score_i > max_q) max_new = score_i;
    end
    cnt_d = cnt_q;
    max_d = max_q;
    if (accept_i) begin
      if (last_in_i) begin
        cnt_d = '0;
        max_d = {1'b1, {(ScoreW-1){1'b0}}};
      end else begin
        cnt_d = cnt_new;
        max_d = max_new;
      end
    end
  end

  assign push_o    = accept_i && last_in_i;
  assign job_o.n   = cnt_new;
  assign job_o.max = max_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      max_q <= {1'b1, {(ScoreW-1){1'b0}}};
    end else begin
      cnt_q <= cnt_d;
      max_q <= max_d;
    end
  end

  // Element store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (accept_i && room) store_q[cnt_q[IdxW-1:0]] <= score_i;
    if (rd_req_i.en) rd_data_o <= store_q[rd_req_i.addr];
  end

endmodule

`default_nettype wire

/* hw/rtl/svf_job_fifo.sv */
// ----------------------------------------------------------------------------
// svf_job_fifo
// Two-entry queue of vector jobs between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module svf_job_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire svf_pkg::job_t job_i,
  input  wire logic          pop_i,
  output logic               empty_o,
  output svf_pkg::job_t      job_o
);
  import svf_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign empty_o = (cnt_q == 2'd0);
  assign job_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && cnt_q != 2'd2) mem_q[wp_q] <= job_i;
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && cnt_q != 2'd2) wp_q <= ~wp_q;
      if (pop_i && !empty_o) rp_q <= ~rp_q;
      case ({push_i && cnt_q != 2'd2, pop_i && !empty_o})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/svf_exp.sv */
// ----------------------------------------------------------------------------
// svf_exp
// Four-stage exp(x - max) unit: log2(e) scaling, table lookup, interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module svf_exp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              valid_i,
  input  wire logic signed [svf_pkg::ScoreW-1:0] x_i,
  input  wire logic signed [svf_pkg::ScoreW-1:0] max_i,
  output logic                                   valid_o,
  output logic [svf_pkg::ExpW-1:0]               e_o
);
  import svf_pkg::*;

  logic signed [ScoreW:0] dif;
  logic [32:0]            prod;
  logic [24:0]            u_q;
  logic [16:0]            tab0, tab1, tabd;
  logic [16:0]            t0_q, t0b_q;
  logic [11:0]            dif_q, r_q;
  logic [4:0]             n_q, nb_q;
  logic                   big_q, bigb_q;
  logic [23:0]            mul_q;
  logic [16:0]            v;
  logic [2:0]             vld_q;

  // Stage 1: |d| * log2(e)
  always_comb begin
    dif  = {max_i[ScoreW-1], max_i} - {x_i[ScoreW-1], x_i};
    prod = 33'(dif[ScoreW-1:0]) * 33'(Log2eQ16);
  end

  // Stage 2: table pair around the fraction
  always_comb begin
    tab0 = pow2_lut({1'b0, u_q[15:12]});
    tab1 = pow2_lut({1'b0, u_q[15:12]} + 5'd1);
    tabd = tab0 - tab1;
  end

  // Stage 4: interpolate and shift by the integer part
  always_comb begin
    v = t0b_q - {5'd0, mul_q[23:12]};
  end

  always_ff @(posedge clk_i) begin
    u_q    <= prod[32:8];
    t0_q   <= tab0;
    dif_q  <= tabd[11:0];
    r_q    <= u_q[11:0];
    n_q    <= u_q[20:16];
    big_q  <= (u_q[24:16] >= 9'd17);
    mul_q  <= 24'(dif_q) * 24'(r_q);
    t0b_q  <= t0_q;
    nb_q   <= n_q;
    bigb_q <= big_q;
    e_o    <= bigb_q ? '0 : (v >> nb_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_o <= 1'b0;
    end else begin
      vld_q   <= {vld_q[1:0], valid_i};
      valid_o <= vld_q[2];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/svf_back.sv */
// ----------------------------------------------------------------------------
// svf_back
// Walks a stored vector twice: exp sum pass, then per-element division.
// ----------------------------------------------------------------------------
`default_nettype none

module svf_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           job_vld_i,
  input  wire svf_pkg::job_t                  job_i,
  output logic                                pop_o,
  output logic                                idle_o,
  output svf_pkg::rd_req_t                    rd_req_o,
  input  wire logic [svf_pkg::ScoreW-1:0]     rd_data_i,
  output logic                                valid_o,
  output logic [svf_pkg::ProbW-1:0]           prob_o,
  output logic [svf_pkg::EIdxW-1:0]           elem_index_o,
  output logic                                last_out_o
);
  import svf_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SUM  = 6'b000010,
    S_RD   = 6'b000100,
    S_EXP  = 6'b001000,
    S_DIV  = 6'b010000,
    S_PAD  = 6'b100000
  } state_e;

  state_e                   st_q;
  logic [CntW-1:0]          n_q, rd_cnt_q, acc_cnt_q, idx_q;
  logic signed [ScoreW-1:0] max_q;
  logic [SumW-1:0]          sum_q;
  logic [SumW:0]            sum_add;
  logic                     rd_vld_q;
  logic                     e_vld;
  logic [ExpW-1:0]          e;
  logic [SumW-1:0]          rem_q;
  logic [ExpW-1:0]          dvd_q, quo_q;
  logic [4:0]               step_q;
  logic [SumW:0]            trial;
  logic                     qbit;
  logic [ExpW-1:0]          quo_n;

  svf_exp u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rd_vld_q),
    .x_i     (rd_data_i),
    .max_i   (max_q),
    .valid_o (e_vld),
    .e_o     (e)
  );

  assign idle_o = (st_q == S_IDLE);
  assign pop_o  = idle_o && job_vld_i;

  // Read issue: pipelined in the sum pass, one per element in the divide pass
  always_comb begin
    rd_req_o.en   = 1'b0;
    rd_req_o.addr = rd_cnt_q[IdxW-1:0];
    if (st_q == S_SUM && rd_cnt_q < n_q) begin
      rd_req_o.en = 1'b1;
    end else if (st_q == S_RD) begin
      rd_req_o.en   = 1'b1;
      rd_req_o.addr = idx_q[IdxW-1:0];
    end
  end

  // Saturating accumulate and one restoring divide step
  always_comb begin
    sum_add = {1'b0, sum_q} + (SumW+1)'(e);
    trial   = {rem_q, dvd_q[ExpW-1]} - {1'b0, sum_q};
    qbit    = !trial[SumW];
    quo_n   = {quo_q[ExpW-2:0], qbit};
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      S_EXP: begin
        rem_q <= SumW'(e >> 1);
        dvd_q <= {e[0], {(ExpW-1){1'b0}}};
        quo_q <= '0;
      end
      S_DIV: begin
        rem_q <= qbit ? trial[SumW-1:0] : {rem_q[SumW-2:0], dvd_q[ExpW-1]};
        dvd_q <= {dvd_q[ExpW-2:0], 1'b0};
        quo_q <= quo_n;
      end
      default: ;
    endcase
    if (st_q == S_DIV && step_q == 5'(ExpW-1)) begin
      if (sum_q == '0)       prob_o <= '0;
      else if (quo_n[ExpW-1]) prob_o <= {ProbW{1'b1}};
      else                    prob_o <= quo_n[ProbW-1:0];
      elem_index_o <= EIdxW'(idx_q);
      last_out_o   <= (idx_q == n_q - CntW'(1));
    end
  end

  // Control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      n_q       <= '0;
      max_q     <= '0;
      rd_cnt_q  <= '0;
      acc_cnt_q <= '0;
      idx_q     <= '0;
      sum_q     <= '0;
      step_q    <= '0;
      rd_vld_q  <= 1'b0;
      valid_o   <= 1'b0;
    end else begin
      rd_vld_q <= rd_req_o.en;
      valid_o  <= 1'b0;
      unique case (st_q)
        S_IDLE: begin
          if (job_vld_i) begin
            n_q       <= job_i.n;
            max_q     <= job_i.max;
            rd_cnt_q  <= '0;
            acc_cnt_q <= '0;
            sum_q     <= '0;
            idx_q     <= '0;
            st_q      <= S_SUM;
          end
        end
        S_SUM: begin
          if (rd_req_o.en) rd_cnt_q <= rd_cnt_q + CntW'(1);
          if (e_vld) begin
            sum_q     <= sum_add[SumW] ? SumMax : sum_add[SumW-1:0];
            acc_cnt_q <= acc_cnt_q + CntW'(1);
            if (acc_cnt_q + CntW'(1) == n_q) st_q <= S_RD;
          end
        end
        S_RD: st_q <= S_EXP;
        S_EXP: begin
          if (e_vld) begin
            step_q <= '0;
            st_q   <= S_DIV;
          end
        end
        S_DIV: begin
          step_q <= step_q + 5'd1;
          if (step_q == 5'(ExpW-1)) begin
            valid_o <= 1'b1;
            st_q    <= S_PAD;
          end
        end
        S_PAD: begin
          if (idx_q == n_q - CntW'(1)) begin
            st_q <= S_IDLE;
          end else begin
            idx_q <= idx_q + CntW'(1);
            st_q  <= S_RD;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sim/tb_softmax_vector_forward.sv */
// ----------------------------------------------------------------------------
// tb_softmax_vector_forward
// Self-checking bench for the max-shifted softmax block. Vectors of scores
// are sent through the start/busy command port; a scoreboard recomputes the
// fixed-point softmax of each vector and checks every strobed result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_softmax_vector_forward;
  import svf_pkg::*;

  localparam int unsigned WdogLimit = 20000;

  // Expected result of one element
  typedef struct packed {
    logic [ProbW-1:0] prob;
    logic [EIdxW-1:0] idx;
    logic             last;
  } prob_res_t;

  // Softmax predictor and queue of expected probabilities
  class softmax_scoreboard;
    logic signed [ScoreW-1:0] elems[$];
    logic signed [ScoreW-1:0] vmax;
    prob_res_t pending[$];
    int errors;

    function new();
      vmax = -16'sd32768;
      errors = 0;
    endfunction

    function automatic logic [16:0] pow2(input int i);
      logic [16:0] t[17];
      t = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
            44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
      return t[i];
    endfunction

    // exp(-t/256) in Q1.16
    function automatic logic [16:0] exp_neg(input logic [31:0] t);
      logic [63:0] u;
      logic [63:0] n;
      logic [15:0] f;
      logic [31:0] v;
      u = (64'(t) * 64'd94549) >> 8;
      n = u >> 16;
      f = u[15:0];
      v = 32'(pow2(f[15:12])) - (((32'(pow2(f[15:12])) - 32'(pow2(f[15:12] + 1)))
          * 32'(f[11:0])) >> 12);
      if (n >= 17) return 17'd0;
      return 17'(v >> n);
    endfunction

    // Note an accepted command transaction
    function void note_score(input logic signed [ScoreW-1:0] x, input logic last);
      logic [31:0] sum;
      logic [63:0] p;
      logic [31:0] t;
      prob_res_t r;
      if (elems.size() < VecLen) begin
        elems.push_back(x);
        if (x > vmax) vmax = x;
      end
      if (!last) return;
      sum = 0;
      foreach (elems[i]) begin
        t = 32'(int'(vmax) - int'(elems[i]));
        sum += exp_neg(t);
        if (sum > 32'h7FFFFF) sum = 32'h7FFFFF;
      end
      foreach (elems[i]) begin
        t = 32'(int'(vmax) - int'(elems[i]));
        p = 0;
        if (sum != 0) begin
          p = (64'(exp_neg(t)) << 16) / sum;
          if (p > 65535) p = 65535;
        end
        r.prob = p[15:0];
        r.idx  = EIdxW'(i);
        r.last = (i == elems.size() - 1);
        pending.push_back(r);
      end
      elems.delete();
      vmax = -16'sd32768;
    endfunction

    // Check one strobed result
    function void check_result(input logic [ProbW-1:0] prob,
                               input logic [EIdxW-1:0] idx, input logic last);
      prob_res_t e;
      if (pending.size() == 0) begin
        $error("unexpected result prob=%0d index=%0d", prob, idx);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (prob !== e.prob) begin
        $error("prob: expected %0d, got %0d", e.prob, prob); errors++;
      end
      if (idx !== e.idx) begin
        $error("elem_index: expected %0d, got %0d", e.idx, idx); errors++;
      end
      if (last !== e.last) begin
        $error("last_out: expected %0d, got %0d", e.last, last); errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic start, busy;
  logic signed [ScoreW-1:0] score_i;
  logic last_in_i;
  logic valid_o;
  logic [ProbW-1:0] prob_o;
  logic [EIdxW-1:0] elem_index_o;
  logic last_out_o;

  softmax_scoreboard sb;
  int idle_pct;
  int quiet_cycles;
  bit timed_out;

  softmax_vector_forward dut (
    .clk_i, .rst_ni, .start, .busy, .score_i, .last_in_i,
    .valid_o, .prob_o, .elem_index_o, .last_out_o
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Result monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) sb.check_result(prob_o, elem_index_o, last_out_o);
      if (valid_o || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WdogLimit) timed_out = 1'b1;
    end
  end

  // Send one score; returns once the transaction is accepted.
  // start stays high afterwards until the next call or the end of stimulus.
  task automatic send_score(input logic signed [ScoreW-1:0] x, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start     <= 1'b1;
    score_i   <= x;
    last_in_i <= last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_score(x, last);
  endtask

  // One vector of the given length; draws from a narrow band or the full range
  task automatic send_vector(input int len);
    logic signed [ScoreW-1:0] base, x;
    int spread;
    base = 16'($urandom);
    spread = ($urandom_range(1)) ? 16'hFFFF : $urandom_range(4096);
    for (int i = 0; i < len; i++) begin
      x = (spread == 16'hFFFF) ? 16'($urandom) : base + 16'($urandom_range(spread));
      send_score(x, i == len - 1);
    end
  endtask

  initial begin
    int sent;
    sb = new();
    rst_ni = 1'b0;
    start = 1'b0;
    score_i = '0;
    last_in_i = 1'b0;
    quiet_cycles = 0;
    timed_out = 1'b0;
    idle_pct = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, single element, equal scores, over-long vector
    send_score(16'sh7FFF, 1'b1);
    send_score(-16'sd32768, 1'b1);
    send_score(-16'sd32768, 1'b0);
    send_score(16'sh7FFF, 1'b1);
    send_score(16'sh0000, 1'b0);
    send_score(16'sh0000, 1'b0);
    send_score(16'sh0000, 1'b1);
    send_score(16'sh5555, 1'b0);
    send_score(-16'sh5556, 1'b1);
    for (int i = 0; i < 19; i++) send_score(16'(i * 37 - 300), i == 18);

    // Random vectors over the idle phases
    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 71 : (ph == 3) ? 34 : 0;
      while (sent < 26 * (ph + 1)) begin
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 6);
        send_vector(len);
        sent += len;
      end
    end
    start <= 1'b0;

    while (sb.pending.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (timed_out) begin
      $display("tb: failure");
    end else if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Timeout while the driver is blocked on a handshake
  always @(posedge clk_i) begin
    if (quiet_cycles > WdogLimit + 10) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

`default_nettype wire
